// ===== rtl/rgb2hsv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb2hsv_pkg
// Shared widths, constants and pipeline types of the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rgb2hsv_pkg;

	localparam int CH_W      = 8;            // one colour channel
	localparam int HUE_W     = 16;           // hue, Q0.16
	localparam int SAT_W     = 17;           // saturation, Q1.16
	localparam int SATQ_W    = 16;           // fractional quotient bits of saturation
	localparam int HDIV_W    = 11;           // 6*delta, up to 1530
	localparam int HNUM_W    = HDIV_W + 1;   // signed hue numerator before wrap
	localparam int SDIV_W    = CH_W;         // max channel

	localparam int BITS_PER_STAGE = 4;
	localparam int DIV_STAGES     = HUE_W / BITS_PER_STAGE;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	localparam logic [SAT_W-1:0] SAT_ONE = SAT_W'(1) << SATQ_W;

	// Pipeline payload: two restoring dividers in flight side by side.
	typedef struct packed {
		logic [HDIV_W-1:0] hue_rem;
		logic [HDIV_W-1:0] hue_div;
		logic [HUE_W-1:0]  hue_q;
		logic [SDIV_W-1:0] sat_rem;
		logic [SDIV_W-1:0] sat_div;
		logic [SATQ_W-1:0] sat_q;
		logic              sat_full;
		logic [CH_W-1:0]   value_level;
		logic              hue_valid;
	} stage_t;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [SAT_W-1:0] saturation;
		logic [CH_W-1:0]  value_level;
		logic             hue_valid;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/rgb2hsv_prep.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb2hsv_prep
// Max/min, sector pick and divider set-up for one pixel.
// ----------------------------------------------------------------------------
module rgb2hsv_prep (
	input  wire logic [rgb2hsv_pkg::CH_W-1:0] red,
	input  wire logic [rgb2hsv_pkg::CH_W-1:0] green,
	input  wire logic [rgb2hsv_pkg::CH_W-1:0] blue,
	output rgb2hsv_pkg::stage_t               stage
);

	logic                               red_max;
	logic                               green_max;
	logic [rgb2hsv_pkg::CH_W-1:0]       mx;
	logic [rgb2hsv_pkg::CH_W-1:0]       mn;
	logic [rgb2hsv_pkg::CH_W-1:0]       delta;
	logic [rgb2hsv_pkg::HDIV_W-1:0]     d6;
	logic [rgb2hsv_pkg::HNUM_W-1:0]     num;
	logic [rgb2hsv_pkg::HNUM_W-1:0]     r_x;
	logic [rgb2hsv_pkg::HNUM_W-1:0]     g_x;
	logic [rgb2hsv_pkg::HNUM_W-1:0]     b_x;
	logic [rgb2hsv_pkg::HNUM_W-1:0]     d_x;

	// ties: red before green before blue
	assign red_max   = (red >= green) && (red >= blue);
	assign green_max = !red_max && (green >= blue);

	always_comb begin
		priority if (red_max) begin
			mx = red;
		end else if (green_max) begin
			mx = green;
		end else begin
			mx = blue;
		end
	end

	always_comb begin
		priority if ((red <= green) && (red <= blue)) begin
			mn = red;
		end else if (green <= blue) begin
			mn = green;
		end else begin
			mn = blue;
		end
	end

	assign delta = mx - mn;
	assign d6    = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};

	assign r_x = rgb2hsv_pkg::HNUM_W'(red);
	assign g_x = rgb2hsv_pkg::HNUM_W'(green);
	assign b_x = rgb2hsv_pkg::HNUM_W'(blue);
	assign d_x = rgb2hsv_pkg::HNUM_W'(delta);

	always_comb begin
		priority if (red_max) begin
			num = g_x - b_x;
			if (num[rgb2hsv_pkg::HNUM_W-1]) begin
				num = num + {1'b0, d6};   // negative red sector wraps a full turn
			end
		end else if (green_max) begin
			num = (d_x << 1) + b_x - r_x;
		end else begin
			num = (d_x << 2) + r_x - g_x;
		end
	end

	always_comb begin
		stage             = '0;
		stage.value_level = mx;
		stage.hue_valid   = (delta != '0);
		// gray or black: 0 / 1 keeps the hue quotient at zero
		stage.hue_rem     = (delta != '0) ? num[rgb2hsv_pkg::HDIV_W-1:0] : '0;
		stage.hue_div     = (delta != '0) ? d6 : rgb2hsv_pkg::HDIV_W'(1);
		// delta == max gives exactly one; otherwise delta < max
		stage.sat_full    = (mx != '0) && (delta == mx);
		stage.sat_rem     = (delta == mx) ? '0 : delta;
		stage.sat_div     = (mx != '0) ? mx : rgb2hsv_pkg::SDIV_W'(1);
	end

endmodule
`default_nettype wire

// ===== rtl/rgb2hsv_div_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb2hsv_div_step
// Four restoring-division steps for both the hue and saturation quotients.
// ----------------------------------------------------------------------------
module rgb2hsv_div_step (
	input  wire rgb2hsv_pkg::stage_t cur,
	output rgb2hsv_pkg::stage_t      nxt
);

	logic [rgb2hsv_pkg::HDIV_W:0] h2;
	logic [rgb2hsv_pkg::SDIV_W:0] s2;

	always_comb begin
		nxt = cur;
		h2  = '0;
		s2  = '0;
		for (int i = 0; i < rgb2hsv_pkg::BITS_PER_STAGE; i++) begin
			h2 = {nxt.hue_rem, 1'b0};
			if (h2 >= {1'b0, nxt.hue_div}) begin
				nxt.hue_rem = rgb2hsv_pkg::HDIV_W'(h2 - {1'b0, nxt.hue_div});
				nxt.hue_q   = {nxt.hue_q[rgb2hsv_pkg::HUE_W-2:0], 1'b1};
			end else begin
				nxt.hue_rem = h2[rgb2hsv_pkg::HDIV_W-1:0];
				nxt.hue_q   = {nxt.hue_q[rgb2hsv_pkg::HUE_W-2:0], 1'b0};
			end

			s2 = {nxt.sat_rem, 1'b0};
			if (s2 >= {1'b0, nxt.sat_div}) begin
				nxt.sat_rem = rgb2hsv_pkg::SDIV_W'(s2 - {1'b0, nxt.sat_div});
				nxt.sat_q   = {nxt.sat_q[rgb2hsv_pkg::SATQ_W-2:0], 1'b1};
			end else begin
				nxt.sat_rem = s2[rgb2hsv_pkg::SDIV_W-1:0];
				nxt.sat_q   = {nxt.sat_q[rgb2hsv_pkg::SATQ_W-2:0], 1'b0};
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rgb2hsv_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb2hsv_fifo
// Small result queue that absorbs items still in the pipe during a stall.
// ----------------------------------------------------------------------------
module rgb2hsv_fifo (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire rgb2hsv_pkg::result_t wr_data,
	output logic                      rd_valid,
	input  wire logic                 rd_en,
	output rgb2hsv_pkg::result_t      rd_data
);

	rgb2hsv_pkg::result_t                  mem_q [rgb2hsv_pkg::FIFO_DEPTH];
	logic [rgb2hsv_pkg::FIFO_PTR_W-1:0]    wr_ptr_q;
	logic [rgb2hsv_pkg::FIFO_PTR_W-1:0]    rd_ptr_q;
	logic [rgb2hsv_pkg::FIFO_CNT_W-1:0]    count_q;

	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rgb_to_hsv_converter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_top
// RGB pixel in, HSV out: value = max channel, saturation = delta/max (Q1.16),
// hue = turn fraction (Q0.16) with an undefined-hue flag.
// ----------------------------------------------------------------------------
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+----------------------------------------
//  pixel   | pix_valid  | pix_stall  | red, green, blue
//  hsv     | hsv_valid  | hsv_stall  | hue, saturation, value_level, hue_valid
//
//  Path: an accepted pixel passes the prep stage s1, four division stages
//  s2..s5, then the result queue, whose head drives the hsv channel.
//  Throughput: one item per cycle while pix_stall is low; the pipe never
//  stops; each division stage yields four hue and four saturation bits.
//  Stalls: an 8-entry result queue backs the pipe; a credit count of items
//  accepted but not delivered raises pix_stall only when all 8 are taken,
//  so pix_stall is decoded from the credit register alone.
//  Reset: arst_n clears valid bits, queue pointers and the credit count.
//
module rgb_to_hsv_converter_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           pix_valid,
	output logic                                pix_stall,
	input  wire logic [rgb2hsv_pkg::CH_W-1:0]   red,
	input  wire logic [rgb2hsv_pkg::CH_W-1:0]   green,
	input  wire logic [rgb2hsv_pkg::CH_W-1:0]   blue,
	output logic                                hsv_valid,
	input  wire logic                           hsv_stall,
	output logic [rgb2hsv_pkg::HUE_W-1:0]       hue,
	output logic [rgb2hsv_pkg::SAT_W-1:0]       saturation,
	output logic [rgb2hsv_pkg::CH_W-1:0]        value_level,
	output logic                                hue_valid
);

	logic pix_take;
	logic hsv_take;

	// credit count: items inside pipe plus queue
	logic [rgb2hsv_pkg::FIFO_CNT_W-1:0] credit_q;

	rgb2hsv_pkg::stage_t prep_out;
	rgb2hsv_pkg::stage_t div2_out;
	rgb2hsv_pkg::stage_t div3_out;
	rgb2hsv_pkg::stage_t div4_out;
	rgb2hsv_pkg::stage_t div5_out;

	rgb2hsv_pkg::stage_t stage_s1;
	rgb2hsv_pkg::stage_t stage_s2;
	rgb2hsv_pkg::stage_t stage_s3;
	rgb2hsv_pkg::stage_t stage_s4;
	rgb2hsv_pkg::stage_t stage_s5;
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;
	logic valid_s5;

	rgb2hsv_pkg::result_t res;
	rgb2hsv_pkg::result_t head;

	assign pix_stall = (credit_q == rgb2hsv_pkg::FIFO_CNT_W'(rgb2hsv_pkg::FIFO_DEPTH));
	assign pix_take  = pix_valid && !pix_stall;
	assign hsv_take  = hsv_valid && !hsv_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			unique case ({pix_take, hsv_take})
				2'b10:   credit_q <= credit_q + 1'b1;
				2'b01:   credit_q <= credit_q - 1'b1;
				default: credit_q <= credit_q;
			endcase
		end
	end

	// stage 1: max/min, sector, numerator and divisors
	rgb2hsv_prep u_prep (
		.red   (red),
		.green (green),
		.blue  (blue),
		.stage (prep_out)
	);

	// stages 2..5: four quotient bits each
	rgb2hsv_div_step u_div2 (.cur(stage_s1), .nxt(div2_out));
	rgb2hsv_div_step u_div3 (.cur(stage_s2), .nxt(div3_out));
	rgb2hsv_div_step u_div4 (.cur(stage_s3), .nxt(div4_out));
	rgb2hsv_div_step u_div5 (.cur(stage_s4), .nxt(div5_out));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= pix_take;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		stage_s1 <= prep_out;
		stage_s2 <= div2_out;
		stage_s3 <= div3_out;
		stage_s4 <= div4_out;
		stage_s5 <= div5_out;
	end

	// gray/black pixels leave a zero hue quotient, so no masking needed
	always_comb begin
		res.hue         = stage_s5.hue_q;
		res.saturation  = stage_s5.sat_full ? rgb2hsv_pkg::SAT_ONE
		                                    : rgb2hsv_pkg::SAT_W'(stage_s5.sat_q);
		res.value_level = stage_s5.value_level;
		res.hue_valid   = stage_s5.hue_valid;
	end

	// queue cannot overflow: credits bound its fill
	rgb2hsv_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (valid_s5),
		.wr_data  (res),
		.rd_valid (hsv_valid),
		.rd_en    (hsv_take),
		.rd_data  (head)
	);

	assign hue         = head.hue;
	assign saturation  = head.saturation;
	assign value_level = head.value_level;
	assign hue_valid   = head.hue_valid;

endmodule
`default_nettype wire

// ===== rtl/rgb2hsv_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb2hsv_checker
// Port-level checks of the converter, bound onto the top level.
// ----------------------------------------------------------------------------
module rgb2hsv_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           pix_valid,
	input wire logic                           pix_stall,
	input wire logic                           hsv_valid,
	input wire logic                           hsv_stall,
	input wire logic [rgb2hsv_pkg::HUE_W-1:0]  hue,
	input wire logic [rgb2hsv_pkg::SAT_W-1:0]  saturation,
	input wire logic [rgb2hsv_pkg::CH_W-1:0]   value_level,
	input wire logic                           hue_valid
);

	logic                                 pix_take;
	logic                                 hsv_take;
	logic [rgb2hsv_pkg::FIFO_CNT_W:0]     pending_q;

	assign pix_take = pix_valid && !pix_stall;
	assign hsv_take = hsv_valid && !hsv_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + (pix_take ? 1'b1 : 1'b0) - (hsv_take ? 1'b1 : 1'b0);
		end
	end

	// a held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && hsv_stall |=> hsv_valid && $stable(hue) && $stable(saturation)
			&& $stable(value_level) && $stable(hue_valid))
		else $error("stalled result changed");

	// no result without an item behind it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> pending_q != '0)
		else $error("result without pending item");

	// the pixel side only stalls when the queue's worth of items is pending
	a_stall_credit: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q < rgb2hsv_pkg::FIFO_DEPTH |-> !pix_stall)
		else $error("pixel stalled with free credit");

	// undefined hue: gray or black, so hue and saturation are zero
	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && !hue_valid |-> hue == '0 && saturation == '0)
		else $error("undefined hue with nonzero hue or saturation");

	// full saturation means min is zero and max is not, so hue is defined
	a_full_sat: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && saturation[rgb2hsv_pkg::SATQ_W] |->
			hue_valid && saturation[rgb2hsv_pkg::SATQ_W-1:0] == '0 && value_level != '0)
		else $error("inconsistent full saturation");

endmodule

bind rgb_to_hsv_converter_top rgb2hsv_checker u_rgb2hsv_checker (.*);
`default_nettype wire
